### hw/rtl/asmf_pkg.sv
// ----------------------------------------------------------------------------
// asmf_pkg
// Shared constants, types and helpers of the accelerometer median filter.
// ----------------------------------------------------------------------------
package asmf_pkg;

    localparam int WINDOW      = 5;
    localparam int SAMPLE_BITS = 16;
    localparam int BIAS_BITS   = 13;
    localparam int OUT_BITS    = SAMPLE_BITS + 1;
    localparam int IDX_BITS    = $clog2(WINDOW);
    localparam int RANK_BITS   = $clog2(WINDOW);
    localparam int TWO_G       = 1 << (SAMPLE_BITS - 1);
    localparam int MEDIAN_RANK = WINDOW / 2;

    localparam int NUM_AXES    = 3;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    localparam logic signed [BIAS_BITS-1:0] BIAS_X_RESET = BIAS_BITS'(270);
    localparam logic signed [BIAS_BITS-1:0] BIAS_Y_RESET = BIAS_BITS'(332);
    localparam logic signed [BIAS_BITS-1:0] BIAS_Z_RESET = BIAS_BITS'(1811);

    typedef logic signed [OUT_BITS-1:0]    sample_t;
    typedef logic signed [SAMPLE_BITS-1:0] raw_t;
    typedef logic signed [BIAS_BITS-1:0]   bias_t;
    typedef sample_t                       window_t [WINDOW];

    typedef enum logic [1:0] {
        REG_BIAS_X = 2'd0,
        REG_BIAS_Y = 2'd1,
        REG_BIAS_Z = 2'd2
    } reg_idx_t;

    // Reset content of a shift-line position. The last position drops out
    // first, so it carries the first window slot.
    function automatic sample_t preload_value(input int unsigned pos);
        int unsigned slot;
        slot = WINDOW - 1 - pos;
        if (slot == 0) begin
            return '0;
        end else if (slot[0]) begin
            return sample_t'(-TWO_G);
        end else begin
            return sample_t'(TWO_G);
        end
    endfunction

endpackage

### hw/rtl/accel_sliding_median_filter_core.sv
// ----------------------------------------------------------------------------
// accel_sliding_median_filter_core
// Bias correction and five-sample sliding median on three accelerometer axes.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one raw x/y/z sample per item. Each axis has the bias
// register for that axis subtracted and the difference shifts into a row of
// cells that holds the last WINDOW corrected samples. The m_ channel returns
// the median of each axis window for every item.
// The edge that accepts an item shifts the sample into the cell row, and
// every cell then ranks itself against its neighbors; the middle-ranked
// value is registered and m_valid rises once the output register is free
// to capture it.
// Throughput is one item per cycle while m_ready keeps up; it is set by the
// cell row, which shifts once per accepted item.
// Reset loads the bias registers with their defaults and preloads each window
// with 0, -2 g, +2 g, -2 g, +2 g. When the receiver stalls, one result waits
// in the output register and one more item can still enter the window, after
// which s_ready drops until m_ready returns.
// Bias registers sit at byte addresses 0, 4 and 8 of the APB port.
// ----------------------------------------------------------------------------
module accel_sliding_median_filter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  asmf_pkg::raw_t                      s_raw_x,
    input  asmf_pkg::raw_t                      s_raw_y,
    input  asmf_pkg::raw_t                      s_raw_z,
    // Result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output asmf_pkg::sample_t                   m_median_x,
    output asmf_pkg::sample_t                   m_median_y,
    output asmf_pkg::sample_t                   m_median_z,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [asmf_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [asmf_pkg::DATA_BITS-1:0]      pwdata,
    output logic [asmf_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);
    import asmf_pkg::*;

    bias_t    bias_reg [NUM_AXES];
    bias_t    bias_next [NUM_AXES];
    raw_t     raw [NUM_AXES];
    sample_t  corr [NUM_AXES];
    sample_t  med [NUM_AXES];
    sample_t  median_reg [NUM_AXES];
    sample_t  median_next [NUM_AXES];

    logic     win_valid_reg;
    logic     win_valid_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     accept;
    logic     capture;
    logic     out_free;
    logic     cfg_write;
    reg_idx_t cfg_idx;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            bias_next[a] = bias_reg[a];
        end
        if (cfg_write) begin
            unique case (cfg_idx)
                REG_BIAS_X: bias_next[0] = pwdata[BIAS_BITS-1:0];
                REG_BIAS_Y: bias_next[1] = pwdata[BIAS_BITS-1:0];
                REG_BIAS_Z: bias_next[2] = pwdata[BIAS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg[0] <= BIAS_X_RESET;
            bias_reg[1] <= BIAS_Y_RESET;
            bias_reg[2] <= BIAS_Z_RESET;
        end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
                bias_reg[a] <= bias_next[a];
            end
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BIAS_X: prdata = {{(DATA_BITS-BIAS_BITS){bias_reg[0][BIAS_BITS-1]}}, bias_reg[0]};
            REG_BIAS_Y: prdata = {{(DATA_BITS-BIAS_BITS){bias_reg[1][BIAS_BITS-1]}}, bias_reg[1]};
            REG_BIAS_Z: prdata = {{(DATA_BITS-BIAS_BITS){bias_reg[2][BIAS_BITS-1]}}, bias_reg[2]};
            default:    prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !win_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign capture  = win_valid_reg && out_free;

    always_comb begin
        if (accept) begin
            win_valid_next = 1'b1;
        end else if (capture) begin
            win_valid_next = 1'b0;
        end else begin
            win_valid_next = win_valid_reg;
        end

        if (capture) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            win_valid_reg <= win_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- datapath ----------------
    assign raw[0] = s_raw_x;
    assign raw[1] = s_raw_y;
    assign raw[2] = s_raw_z;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        assign corr[a] =
            {{(OUT_BITS-SAMPLE_BITS){raw[a][SAMPLE_BITS-1]}}, raw[a]}
            - {{(OUT_BITS-BIAS_BITS){bias_reg[a][BIAS_BITS-1]}}, bias_reg[a]};

        asmf_axis u_axis (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (accept),
            .new_val  (corr[a]),
            .median   (med[a])
        );

        assign median_next[a] = capture ? med[a] : median_reg[a];

        always_ff @(posedge aclk) begin
            median_reg[a] <= median_next[a];
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_median_x = median_reg[0];
    assign m_median_y = median_reg[1];
    assign m_median_z = median_reg[2];

endmodule

### hw/rtl/asmf_cell.sv
// ----------------------------------------------------------------------------
// asmf_cell
// One window position: holds a sample, passes it on, and ranks itself.
// ----------------------------------------------------------------------------
module asmf_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     shift_en,
    input  asmf_pkg::sample_t        reset_val,
    input  logic [asmf_pkg::IDX_BITS-1:0] my_idx,
    input  asmf_pkg::sample_t        d_in,
    input  asmf_pkg::window_t        window,
    output asmf_pkg::sample_t        q,
    output logic                     sel
);
    import asmf_pkg::*;

    sample_t              value_reg;
    sample_t              value_next;
    logic [RANK_BITS-1:0] rank;

    always_comb begin
        value_next = shift_en ? d_in : value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= reset_val;
        end else begin
            value_reg <= value_next;
        end
    end

    // Equal values are ordered by position, so every cell gets a distinct rank.
    always_comb begin
        rank = '0;
        for (int j = 0; j < WINDOW; j++) begin
            if (IDX_BITS'(j) < my_idx) begin
                if (window[j] <= value_reg) begin
                    rank = rank + RANK_BITS'(1);
                end
            end else if (IDX_BITS'(j) > my_idx) begin
                if (window[j] < value_reg) begin
                    rank = rank + RANK_BITS'(1);
                end
            end
        end
    end

    assign q   = value_reg;
    assign sel = (rank == RANK_BITS'(MEDIAN_RANK));

endmodule

### hw/rtl/asmf_axis.sv
// ----------------------------------------------------------------------------
// asmf_axis
// Chain of window cells for one axis and the median select across them.
// ----------------------------------------------------------------------------
module asmf_axis (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  asmf_pkg::sample_t new_val,
    output asmf_pkg::sample_t median
);
    import asmf_pkg::*;

    window_t           taps;
    logic [WINDOW-1:0] sel;

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        sample_t d_in;
        if (k == 0) begin : g_head
            assign d_in = new_val;
        end else begin : g_body
            assign d_in = taps[k-1];
        end

        asmf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .reset_val (preload_value(k)),
            .my_idx    (IDX_BITS'(k)),
            .d_in      (d_in),
            .window    (taps),
            .q         (taps[k]),
            .sel       (sel[k])
        );
    end

    // Exactly one cell holds the middle rank, so an AND-OR picks it.
    always_comb begin
        median = '0;
        for (int k = 0; k < WINDOW; k++) begin
            median = median | (sel[k] ? taps[k] : sample_t'(0));
        end
    end

endmodule

### bench/asmf_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmf_median_checker
// Watches the sample, result and APB channels of the median filter core,
// predicts each result from its own copy of the bias registers and the
// three axis windows, and compares every result field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module asmf_median_checker
    import asmf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  raw_t                 s_raw_x,
    input  raw_t                 s_raw_y,
    input  raw_t                 s_raw_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  sample_t              m_median_x,
    input  sample_t              m_median_y,
    input  sample_t              m_median_z,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    input  logic [DATA_BITS-1:0] prdata,
    input  logic                 pready,
    output int                   mismatches,
    output int                   open_results
);

    typedef logic [NUM_AXES-1:0][OUT_BITS-1:0] median_set_t;

    string       axis_field [NUM_AXES] = '{"median_x", "median_y", "median_z"};
    string       bias_field [NUM_AXES] = '{"bias_x", "bias_y", "bias_z"};

    bias_t       bias_now   [NUM_AXES];
    sample_t     history    [NUM_AXES][WINDOW];
    int unsigned next_slot;
    median_set_t medians_due [$];
    int          fails      = 0;
    int          due_count  = 0;

    assign mismatches   = fails;
    assign open_results = due_count;

    function automatic sample_t median_of(input int axis);
        sample_t t [WINDOW];
        sample_t tmp;
        for (int k = 0; k < WINDOW; k++) t[k] = history[axis][k];
        for (int p = 0; p < WINDOW - 1; p++) begin
            for (int q = 0; q < WINDOW - 1 - p; q++) begin
                if (t[q] > t[q+1]) begin
                    tmp    = t[q];
                    t[q]   = t[q+1];
                    t[q+1] = tmp;
                end
            end
        end
        return t[MEDIAN_RANK];
    endfunction

    always @(posedge aclk) begin
        median_set_t want;
        median_set_t got;
        raw_t        incoming [NUM_AXES];
        sample_t     wide_raw;
        sample_t     wide_bias;
        int          idx;
        if (!aresetn) begin
            bias_now[0] = BIAS_X_RESET;
            bias_now[1] = BIAS_Y_RESET;
            bias_now[2] = BIAS_Z_RESET;
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int k = 0; k < WINDOW; k++) begin
                    if (k == 0) begin
                        history[a][k] = '0;
                    end else if (k % 2 == 1) begin
                        history[a][k] = sample_t'(-TWO_G);
                    end else begin
                        history[a][k] = sample_t'(TWO_G);
                    end
                end
            end
            next_slot = 0;
            medians_due.delete();
        end else begin
            // Byte address 4*i selects bias register i; anything above is ignored.
            idx = int'(paddr[ADDR_BITS-1:2]);
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_BITS-1:2])
                    REG_BIAS_X: bias_now[0] = bias_t'(pwdata[BIAS_BITS-1:0]);
                    REG_BIAS_Y: bias_now[1] = bias_t'(pwdata[BIAS_BITS-1:0]);
                    REG_BIAS_Z: bias_now[2] = bias_t'(pwdata[BIAS_BITS-1:0]);
                    default: ;
                endcase
            end
            if (psel && penable && !pwrite && pready && idx < NUM_AXES) begin
                if (prdata[BIAS_BITS-1:0] !== bias_now[idx]) begin
                    $error("%s readback: expected %0d, got %0d", bias_field[idx],
                           bias_now[idx], $signed(prdata[BIAS_BITS-1:0]));
                    fails++;
                end
            end

            if (m_valid && m_ready) begin
                got[0] = m_median_x;
                got[1] = m_median_y;
                got[2] = m_median_z;
                if (medians_due.size() == 0) begin
                    $error("result item arrived with no prediction pending");
                    fails++;
                end else begin
                    want = medians_due.pop_front();
                    for (int a = 0; a < NUM_AXES; a++) begin
                        if (got[a] !== want[a]) begin
                            $error("%s: expected %0d, got %0d", axis_field[a],
                                   $signed(want[a]), $signed(got[a]));
                            fails++;
                        end
                    end
                end
            end

            if (s_valid && s_ready) begin
                incoming[0] = s_raw_x;
                incoming[1] = s_raw_y;
                incoming[2] = s_raw_z;
                for (int a = 0; a < NUM_AXES; a++) begin
                    wide_raw  = incoming[a];
                    wide_bias = bias_now[a];
                    history[a][next_slot] = wide_raw - wide_bias;
                    want[a] = median_of(a);
                end
                medians_due.push_back(want);
                next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
            end
        end
        due_count <= medians_due.size();
    end

endmodule

### bench/accel_sliding_median_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_sliding_median_filter_core_tb
// Drives raw three-axis samples and bias settings into the median filter
// core, with random gaps on the sample side and random stalls on the result
// side; a checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module accel_sliding_median_filter_core_tb;
    import asmf_pkg::*;

    localparam int                   PHASES       = 6;
    localparam int                   PHASE_ITEMS  = 317;
    localparam logic [ADDR_BITS-1:0] ADDR_UNUSED  = 4'hC;
    localparam raw_t                 RAW_MAX      = 16'sh7FFF;
    localparam raw_t                 RAW_MIN      = 16'sh8000;
    localparam bias_t                BIAS_MAX     = 13'sh0FFF;
    localparam bias_t                BIAS_MIN     = 13'sh1000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    raw_t                 s_raw_x;
    raw_t                 s_raw_y;
    raw_t                 s_raw_z;
    logic                 m_valid;
    logic                 m_ready;
    sample_t              m_median_x;
    sample_t              m_median_y;
    sample_t              m_median_z;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    int                   mismatches;
    int                   open_results;

    int                   tx_gap_pct   = 0;
    int                   rx_stall_pct = 0;

    accel_sliding_median_filter_core dut (.*);
    asmf_median_checker              median_check (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: m_ready drops in random stall bursts.
    initial begin : result_side
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [ADDR_BITS-1:0] reg_addr(input reg_idx_t r);
        return {r, 2'b00};
    endfunction

    task automatic cfg_write(input logic [ADDR_BITS-1:0] a, input logic [DATA_BITS-1:0] d);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_read(input logic [ADDR_BITS-1:0] a);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Bits above the bias width carry noise; the core must ignore them.
    task automatic load_biases(input bias_t bx, input bias_t by, input bias_t bz);
        logic [DATA_BITS-1:0] d;
        bias_t                vals [NUM_AXES];
        reg_idx_t             regs [NUM_AXES];
        vals = '{bx, by, bz};
        regs = '{REG_BIAS_X, REG_BIAS_Y, REG_BIAS_Z};
        for (int a = 0; a < NUM_AXES; a++) begin
            d = $urandom();
            d[BIAS_BITS-1:0] = vals[a];
            cfg_write(reg_addr(regs[a]), d);
        end
        cfg_write(ADDR_UNUSED, $urandom());
        for (int a = 0; a < NUM_AXES; a++) cfg_read(reg_addr(regs[a]));
    endtask

    task automatic offer_sample(input raw_t x, input raw_t y, input raw_t z);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_raw_x <= x;
        s_raw_y <= y;
        s_raw_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic hold_off_input(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (open_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mix of full-range noise, values clustered around a drifting level,
    // rail values and repeats, so the medians see ties and near neighbors.
    function automatic raw_t next_raw(input raw_t prev, input raw_t level);
        int unsigned pick;
        int          v;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return raw_t'($urandom());
        end else if (pick < 70) begin
            v = int'(level) + int'($urandom_range(0, 400)) - 200;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return raw_t'(v);
        end else if (pick < 82) begin
            case ($urandom_range(0, 3))
                0:       return RAW_MAX;
                1:       return RAW_MIN;
                2:       return raw_t'(0);
                default: return raw_t'(-1);
            endcase
        end else begin
            return prev;
        end
    endfunction

    initial begin : stimulus
        raw_t rx, ry, rz;
        raw_t lx, ly, lz;
        s_valid = 1'b0;
        s_raw_x = '0;
        s_raw_y = '0;
        s_raw_z = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        aresetn = 1'b0;
        rx = '0; ry = '0; rz = '0;
        lx = '0; ly = '0; lz = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset biases against the preloaded windows.
        cfg_read(reg_addr(REG_BIAS_X));
        cfg_read(reg_addr(REG_BIAS_Y));
        cfg_read(reg_addr(REG_BIAS_Z));
        offer_sample(0, 0, 0);
        offer_sample(RAW_MAX, RAW_MIN, RAW_MAX);
        offer_sample(RAW_MIN, RAW_MAX, RAW_MIN);
        offer_sample(1, -1, 0);
        offer_sample(-1, 1, 0);
        offer_sample(1000, 2000, 3000);
        offer_sample(1000, 2000, 3000);
        offer_sample(-7, 5, 12);
        drain_results();

        // Extreme biases with rail samples fill the windows to the output range.
        load_biases(BIAS_MIN, BIAS_MAX, BIAS_MIN);
        repeat (5) offer_sample(RAW_MAX, RAW_MIN, RAW_MAX);
        repeat (5) offer_sample(RAW_MIN, RAW_MAX, RAW_MIN);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: load_biases(bias_t'($urandom()), bias_t'($urandom()), bias_t'($urandom()));
                1: load_biases(BIAS_MAX, BIAS_MAX, BIAS_MAX);
                2: load_biases(BIAS_MIN, BIAS_MIN, BIAS_MIN);
                3: load_biases(0, 0, 0);
                4: load_biases(BIAS_MAX, BIAS_MIN, bias_t'($urandom()));
                default: load_biases(BIAS_X_RESET, BIAS_Y_RESET, BIAS_Z_RESET);
            endcase
            case (ph)
                0: begin tx_gap_pct = 20; rx_stall_pct = 20; end
                1: begin tx_gap_pct = 40; rx_stall_pct = 10; end
                2: begin tx_gap_pct = 10; rx_stall_pct = 40; end
                3: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                4: begin tx_gap_pct = 25; rx_stall_pct = 25; end
                default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    lx = raw_t'($urandom());
                    ly = raw_t'($urandom());
                    lz = raw_t'($urandom());
                end
                // Let the pipeline empty completely once in mid-stream.
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                rx = next_raw(rx, lx);
                ry = next_raw(ry, ly);
                rz = next_raw(rz, lz);
                offer_sample(rx, ry, rz);
                if ($urandom_range(0, 99) < tx_gap_pct) begin
                    hold_off_input($urandom_range(1, 7));
                end
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && open_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
